/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// prop must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

/* rtl/rhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rhsv_pkg
// Constants and types shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  // result field widths
  localparam int HUE_BITS = 16;
  localparam int OUT_BITS = 16;

  // sector of the largest component; ties go red, then green, then blue
  localparam int SECT_W = 2;
  localparam logic [SECT_W-1:0] SECT_RED   = 2'd0;
  localparam logic [SECT_W-1:0] SECT_GREEN = 2'd1;
  localparam logic [SECT_W-1:0] SECT_BLUE  = 2'd2;

  // per-beat control that rides alongside the datapath
  typedef struct packed {
    logic valid;    // beat present in this stage
    logic defined;  // components differ, hue is meaningful
    logic neg;      // hue numerator was negative, wrap at the end
  } rhsv_ctl_t;

endpackage

/* rtl/rhsv_front.sv */
// ----------------------------------------------------------------------------
// rhsv_front
// Three-stage front end: max/min and sector, then delta and |diff|, then
// the divider operands for hue and saturation.
// ----------------------------------------------------------------------------
module rhsv_front import rhsv_pkg::*; #(
  parameter int CB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [CB-1:0]   red,
  input  logic [CB-1:0]   green,
  input  logic [CB-1:0]   blue,
  output rhsv_ctl_t       ctl,
  output logic [CB-1:0]   mx,
  output logic [CB+2:0]   hue_rem,
  output logic [CB+2:0]   hue_dvs,
  output logic [CB-1:0]   sat_rem,
  output logic [CB-1:0]   sat_low
);

  localparam int HW = CB + 3;

  // stage 1 registers
  logic              v1;
  logic [SECT_W-1:0] sect1;
  logic [CB-1:0]     mx1, mn1;
  logic [CB:0]       diff1;
  // stage 2 registers
  logic              v2;
  logic [SECT_W-1:0] sect2;
  logic [CB-1:0]     mx2, delta2, absdiff2;
  logic [CB:0]       diff2;
  logic              neg2;
  // stage 3 control registers
  logic              v3;
  logic              defined3;
  logic              neg3;

  logic [SECT_W-1:0] sect1_next;
  logic [CB-1:0]     mx1_next, mn1_next;
  logic [CB:0]       diff1_next;
  logic [CB:0]       diff2_neg;
  logic [HW-1:0]     off_d, num_other;
  logic [2*CB-1:0]   sat_num;

  // stage 1: pick the largest component, smallest one, signed difference
  always_comb begin
    if (red >= green && red >= blue) begin
      sect1_next = SECT_RED;
      mx1_next   = red;
      diff1_next = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sect1_next = SECT_GREEN;
      mx1_next   = green;
      diff1_next = {1'b0, blue} - {1'b0, red};
    end else begin
      sect1_next = SECT_BLUE;
      mx1_next   = blue;
      diff1_next = {1'b0, red} - {1'b0, green};
    end
    if (red <= green && red <= blue) begin
      mn1_next = red;
    end else if (green <= blue) begin
      mn1_next = green;
    end else begin
      mn1_next = blue;
    end
  end

  // stage 2 helpers: magnitude of the difference
  assign diff2_neg = {(CB+1){1'b0}} - diff1;

  // stage 3 helpers: sector offset times delta plus diff, 6*delta, delta*full
  always_comb begin
    case (sect2)
      SECT_GREEN: off_d = {2'b00, delta2, 1'b0};
      SECT_BLUE:  off_d = {1'b0, delta2, 2'b00};
      default:    off_d = '0;
    endcase
  end
  assign num_other = off_d + {{(HW-CB-1){diff2[CB]}}, diff2};
  assign sat_num   = {delta2, {CB{1'b0}}} - {{CB{1'b0}}, delta2};

  // stage 3 control out
  assign ctl = '{valid: v3, defined: defined3, neg: neg3};

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sect1    <= sect1_next;
    mx1      <= mx1_next;
    mn1      <= mn1_next;
    diff1    <= diff1_next;

    sect2    <= sect1;
    mx2      <= mx1;
    delta2   <= mx1 - mn1;
    diff2    <= diff1;
    absdiff2 <= diff1[CB] ? diff2_neg[CB-1:0] : diff1[CB-1:0];
    neg2     <= (sect1 == SECT_RED) && diff1[CB];

    mx       <= mx2;
    defined3 <= (delta2 != '0);
    neg3     <= neg2;
    hue_rem  <= (sect2 == SECT_RED) ? {3'b000, absdiff2} : num_other;
    hue_dvs  <= {1'b0, delta2, 2'b00} + {2'b00, delta2, 1'b0};
    sat_rem  <= sat_num[2*CB-1:CB];
    sat_low  <= sat_num[CB-1:0];
  end

endmodule

/* rtl/rhsv_div_step.sv */
// ----------------------------------------------------------------------------
// rhsv_div_step
// One registered step of a restoring divider. The dividend bits still to be
// brought down and the quotient bits already made share one shift register.
// ----------------------------------------------------------------------------
module rhsv_div_step #(
  parameter int W      = 16,
  parameter int QW     = 16,
  parameter bit ACTIVE = 1'b1
) (
  input  logic          clk,
  input  logic [W-1:0]  rem,
  input  logic [W-1:0]  dvs,
  input  logic [QW-1:0] nq,
  output logic [W-1:0]  rem_q,
  output logic [W-1:0]  dvs_q,
  output logic [QW-1:0] nq_q
);

  logic [W:0]    trial, sub;
  logic          fits;
  logic [W-1:0]  rem_next;
  logic [QW-1:0] nq_next;

  // bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, nq[QW-1]};
    sub   = trial - {1'b0, dvs};
    fits  = !sub[W];
    if (ACTIVE) begin
      rem_next = fits ? sub[W-1:0] : trial[W-1:0];
      nq_next  = {nq[QW-2:0], fits};
    end else begin
      rem_next = rem;
      nq_next  = nq;
    end
  end

  always_ff @(posedge clk) begin
    rem_q <= rem_next;
    dvs_q <= dvs;
    nq_q  <= nq_next;
  end

endmodule

/* rtl/rgb_to_hsv_convert.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Pipelined RGB to HSV conversion, one pixel per clock.
//
//   port group                 dir  role
//   start, red/green/blue      in   pixel beat, taken when start && !busy
//   busy                       out  always low, the pipe never stalls
//   done, hue/saturation/      out  result beat, valid for one cycle on done
//     brightness/hue_defined
//
// The pipe is three front stages, one divider step per stage for hue and
// saturation side by side, and one output register. A new pixel is taken
// every cycle. rst (synchronous) empties the pipe; results of pixels in
// flight are dropped. No stalls on either side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsv_convert import rhsv_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output logic                      done,
  output logic [HUE_BITS-1:0]       hue,
  output logic [OUT_BITS-1:0]       saturation,
  output logic [OUT_BITS-1:0]       brightness,
  output logic                      hue_defined
);

  localparam int CB      = COMPONENT_BITS;
  localparam int HW      = CB + 3;
  localparam int NDIV    = (CB > HUE_BITS) ? CB : HUE_BITS;
  localparam int LATENCY = NDIV + 4;

  rhsv_ctl_t     ctl_pipe [0:NDIV];
  logic [CB-1:0] mx_pipe  [0:NDIV];

  logic [HW-1:0]       h_rem [0:NDIV];
  logic [HW-1:0]       h_dvs [0:NDIV];
  logic [HUE_BITS-1:0] h_nq  [0:NDIV];
  logic [CB-1:0]       s_rem [0:NDIV];
  logic [CB-1:0]       s_dvs [0:NDIV];
  logic [CB-1:0]       s_nq  [0:NDIV];

  logic [HUE_BITS-1:0] hue_wrap;

  // never holds off a pixel
  assign busy = 1'b0;

  // front end
  rhsv_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .ctl      (ctl_pipe[0]),
    .mx       (mx_pipe[0]),
    .hue_rem  (h_rem[0]),
    .hue_dvs  (h_dvs[0]),
    .sat_rem  (s_rem[0]),
    .sat_low  (s_nq[0])
  );

  // hue quotient starts empty; saturation divides by the largest component
  assign h_nq[0]  = '0;
  assign s_dvs[0] = mx_pipe[0];

  // divider stages, one quotient bit per stage from each divider while ACTIVE
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    rhsv_div_step #(.W(HW), .QW(HUE_BITS), .ACTIVE(k < HUE_BITS)) u_hue (
      .clk   (clk),
      .rem   (h_rem[k]),
      .dvs   (h_dvs[k]),
      .nq    (h_nq[k]),
      .rem_q (h_rem[k+1]),
      .dvs_q (h_dvs[k+1]),
      .nq_q  (h_nq[k+1])
    );
    rhsv_div_step #(.W(CB), .QW(CB), .ACTIVE(k < CB)) u_sat (
      .clk   (clk),
      .rem   (s_rem[k]),
      .dvs   (s_dvs[k]),
      .nq    (s_nq[k]),
      .rem_q (s_rem[k+1]),
      .dvs_q (s_dvs[k+1]),
      .nq_q  (s_nq[k+1])
    );
  end

  // control and brightness ride along with the divider
  for (genvar k = 1; k <= NDIV; k++) begin : g_ride
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_pipe[k].valid <= 1'b0;
      end else begin
        ctl_pipe[k].valid <= ctl_pipe[k-1].valid;
      end
      ctl_pipe[k].defined <= ctl_pipe[k-1].defined;
      ctl_pipe[k].neg     <= ctl_pipe[k-1].neg;
      mx_pipe[k]          <= mx_pipe[k-1];
    end
  end

  // negative hue wraps by one full turn
  assign hue_wrap = ctl_pipe[NDIV].neg ? (HUE_BITS'(0) - h_nq[NDIV]) : h_nq[NDIV];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_pipe[NDIV].valid;
    end
    hue         <= ctl_pipe[NDIV].defined ? hue_wrap : '0;
    saturation  <= (mx_pipe[NDIV] == '0) ? '0 : OUT_BITS'(s_nq[NDIV]);
    brightness  <= OUT_BITS'(mx_pipe[NDIV]);
    hue_defined <= ctl_pipe[NDIV].defined;
  end

  // every result beat comes from an accepted pixel
  `ASSERT_ALWAYS(a_done_latency, done |-> $past(start && !busy, LATENCY), "result without pixel")
  // every accepted pixel yields a result beat
  `ASSERT_ALWAYS(a_pixel_result, (start && !busy) |-> ##LATENCY done, "pixel result lost")
  // grey pixels report zero hue
  `ASSERT_NEVER(a_grey_hue, done && !hue_defined && (hue != '0), "grey pixel with hue")

endmodule
